// ===== hw/rtl/lru_page_buffer_manager_assert.svh =====
// Assertion macros for the page buffer manager
`ifndef LRU_PAGE_BUFFER_MANAGER_ASSERT_SVH
`define LRU_PAGE_BUFFER_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define LPBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LPBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LPBM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/lpbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpbm_pkg
// Shared sizes, codes and types of the page buffer manager.
// ----------------------------------------------------------------------------
package lpbm_pkg;
    localparam int NUM_SLOTS    = 16;
    localparam int FILE_ID_BITS = 8;
    localparam int PAGE_BITS    = 24;
    localparam int SLOT_BITS    = $clog2(NUM_SLOTS);
    localparam int CNT_BITS     = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] OP_GET        = 3'd0;
    localparam logic [2:0] OP_MARK_DIRTY = 3'd1;
    localparam logic [2:0] OP_DISCARD    = 3'd2;
    localparam logic [2:0] OP_FLUSH_PAGE = 3'd3;
    localparam logic [2:0] OP_FLUSH_FILE = 3'd4;

    localparam logic [1:0] ACT_DONE      = 2'd0;
    localparam logic [1:0] ACT_FILL      = 2'd1;
    localparam logic [1:0] ACT_WRITEBACK = 2'd2;
    localparam logic [1:0] ACT_ABSENT    = 2'd3;

    typedef struct packed {
        logic [2:0]              op;
        logic [FILE_ID_BITS-1:0] file_id;
        logic [PAGE_BITS-1:0]    page_number;
    } cmd_t;

    typedef struct packed {
        logic [1:0]              action;
        logic [3:0]              slot;
        logic [7:0]              file_id;
        logic [23:0]             page_number;
        logic                    was_hit;
        logic                    is_dirty;
        logic                    last;
    } result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lru_page_buffer_manager.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_buffer_manager
// Page slot manager with LRU eviction, dirty marks and a free-slot stack.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries op, file_id and page_number; output
// channel out_valid/out_ready carries one result transaction per disk step.
// A two-entry queue parts the front from the back, which runs one command at
// a time: get, mark dirty, discard and flush page pass through queue, tag
// match and execute, and a get that evicts adds a fill step. Flush file walks
// all slots, one per cycle unless the output stalls. The single output register
// holds a result until taken; a stalled receiver stalls the back, and the
// front keeps accepting until the queue is full. Unused op codes are taken
// and produce nothing. Reset empties all slots and refills the free stack
// at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "lru_page_buffer_manager_assert.svh"
module lru_page_buffer_manager (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  op,
    input  wire logic [7:0]  file_id,
    input  wire logic [23:0] page_number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       action,
    output logic [3:0]       slot,
    output logic [7:0]       out_file_id,
    output logic [23:0]      out_page_number,
    output logic             was_hit,
    output logic             is_dirty,
    output logic             last
);
    import lpbm_pkg::*;

    cmd_t    in_cmd, q_cmd;
    result_t res;
    logic    q_valid, q_pop;

    assign in_cmd.op          = op;
    assign in_cmd.file_id     = file_id;
    assign in_cmd.page_number = page_number;

    lpbm_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    lpbm_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
    );

    assign action          = res.action;
    assign slot            = res.slot;
    assign out_file_id     = res.file_id;
    assign out_page_number = res.page_number;
    assign was_hit         = res.was_hit;
    assign is_dirty        = res.is_dirty;
    assign last            = res.last;

    `LPBM_ASSERT_IMPL(a_fill_clean, clk, rst_n, out_valid && action == ACT_FILL, !is_dirty && last && !was_hit)
    `LPBM_ASSERT_IMPL(a_absent_slot0, clk, rst_n, out_valid && action == ACT_ABSENT, slot == 4'd0 && last)
    `LPBM_ASSERT_NEXT(a_pop_nonempty, clk, rst_n, q_pop, 1'b1)
endmodule
`default_nettype wire

// ===== hw/rtl/lpbm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpbm_front
// Input stage and two-entry command queue; drops unused op codes.
// ----------------------------------------------------------------------------
module lpbm_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lpbm_pkg::cmd_t in_cmd,
    output logic               q_valid,
    input  wire logic          q_pop,
    output lpbm_pkg::cmd_t     q_cmd
);
    import lpbm_pkg::*;

    cmd_t       buf_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    // unused codes are accepted and dropped here
    assign push     = in_valid && in_ready && (in_cmd.op <= OP_FLUSH_FILE);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = buf_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg ^ push;
        rd_next  = rd_reg ^ q_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_reg] <= in_cmd;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lpbm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpbm_back
// Slot table, LRU ranks and free stack; executes one command at a time.
// ----------------------------------------------------------------------------
module lpbm_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire lpbm_pkg::cmd_t q_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output lpbm_pkg::result_t   out_res
);
    import lpbm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MATCH = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;

    logic [2:0]              state_reg, state_next;
    cmd_t                    cmd_reg;
    logic [NUM_SLOTS-1:0]    valid_reg, dirty_reg;
    logic [FILE_ID_BITS-1:0] file_reg [NUM_SLOTS];
    logic [PAGE_BITS-1:0]    page_reg [NUM_SLOTS];
    logic [SLOT_BITS-1:0]    rank_reg [NUM_SLOTS];
    logic [SLOT_BITS-1:0]    stack_reg [NUM_SLOTS];
    logic [CNT_BITS-1:0]     fcnt_reg;
    logic                    hit_reg;
    logic [SLOT_BITS-1:0]    hslot_reg;
    logic [SLOT_BITS-1:0]    victim_reg;
    logic [SLOT_BITS-1:0]    scan_reg;
    logic                    any_reg;
    result_t                 res_reg;
    logic                    ov_reg;

    logic                    m_hit;
    logic [SLOT_BITS-1:0]    m_slot, m_victim;
    logic                    free_ok;
    logic [SLOT_BITS-1:0]    pop_slot;
    logic [NUM_SLOTS-1:0]    f_match;
    logic                    f_more;

    // parallel tag compare and oldest-slot search
    always_comb
    begin
        m_hit    = 1'b0;
        m_slot   = '0;
        m_victim = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && file_reg[i] == cmd_reg.file_id
                && page_reg[i] == cmd_reg.page_number)
            begin
                m_hit  = 1'b1;
                m_slot = SLOT_BITS'(i);
            end
            if (valid_reg[i] && rank_reg[i] == SLOT_BITS'(NUM_SLOTS - 1))
                m_victim = SLOT_BITS'(i);
        end
    end

    // dirty pages of the file being flushed; f_more flags any beyond the scan point
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
            f_match[i] = valid_reg[i] && dirty_reg[i] && file_reg[i] == cmd_reg.file_id;
    end

    assign f_more   = ((f_match >> scan_reg) >> 1) != '0;

    assign free_ok  = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_res  = res_reg;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign pop_slot = stack_reg[fcnt_reg[SLOT_BITS-1:0] - SLOT_BITS'(1)];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_MATCH;
            ST_MATCH: state_next = (cmd_reg.op == OP_FLUSH_FILE) ? ST_SCAN : ST_EXEC;
            ST_EXEC:
                if (free_ok)
                begin
                    if (cmd_reg.op == OP_GET && !hit_reg && fcnt_reg == '0)
                        state_next = ST_FILL;
                    else
                        state_next = ST_IDLE;
                end
            ST_FILL:  if (free_ok) state_next = ST_IDLE;
            ST_SCAN:
                if (free_ok && scan_reg == SLOT_BITS'(NUM_SLOTS - 1))
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    task automatic emit(input logic [1:0] a, input logic [SLOT_BITS-1:0] s,
                        input logic [FILE_ID_BITS-1:0] f, input logic [PAGE_BITS-1:0] p,
                        input logic h, input logic d, input logic l);
        res_reg.action      <= a;
        res_reg.slot        <= 4'(s);
        res_reg.file_id     <= 8'(f);
        res_reg.page_number <= 24'(p);
        res_reg.was_hit     <= h;
        res_reg.is_dirty    <= d;
        res_reg.last        <= l;
        ov_reg              <= 1'b1;
    endtask

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            fcnt_reg  <= CNT_BITS'(NUM_SLOTS);
            ov_reg    <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
                stack_reg[i] <= SLOT_BITS'(NUM_SLOTS - 1 - i);
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (q_valid)
                        cmd_reg <= q_cmd;
                ST_MATCH:
                begin
                    hit_reg    <= m_hit;
                    hslot_reg  <= m_slot;
                    victim_reg <= m_victim;
                    scan_reg   <= '0;
                    any_reg    <= 1'b0;
                end
                ST_EXEC:
                    if (free_ok)
                    begin
                        if (cmd_reg.op == OP_GET)
                        begin
                            if (hit_reg)
                            begin
                                for (int i = 0; i < NUM_SLOTS; i++)
                                    if (valid_reg[i] && rank_reg[i] < rank_reg[hslot_reg])
                                        rank_reg[i] <= rank_reg[i] + SLOT_BITS'(1);
                                rank_reg[hslot_reg] <= '0;
                                emit(ACT_DONE, hslot_reg, cmd_reg.file_id,
                                     cmd_reg.page_number, 1'b1, dirty_reg[hslot_reg], 1'b1);
                            end
                            else if (fcnt_reg != '0)
                            begin
                                for (int i = 0; i < NUM_SLOTS; i++)
                                    if (valid_reg[i])
                                        rank_reg[i] <= rank_reg[i] + SLOT_BITS'(1);
                                rank_reg[pop_slot]  <= '0;
                                valid_reg[pop_slot] <= 1'b1;
                                dirty_reg[pop_slot] <= 1'b0;
                                file_reg[pop_slot]  <= cmd_reg.file_id;
                                page_reg[pop_slot]  <= cmd_reg.page_number;
                                fcnt_reg            <= fcnt_reg - CNT_BITS'(1);
                                emit(ACT_FILL, pop_slot, cmd_reg.file_id,
                                     cmd_reg.page_number, 1'b0, 1'b0, 1'b1);
                            end
                            else
                            begin
                                // evict oldest; it has the top rank so no shift needed
                                if (dirty_reg[victim_reg])
                                    emit(ACT_WRITEBACK, victim_reg, file_reg[victim_reg],
                                         page_reg[victim_reg], 1'b0, 1'b0, 1'b0);
                                valid_reg[victim_reg] <= 1'b0;
                                dirty_reg[victim_reg] <= 1'b0;
                                stack_reg[0]          <= victim_reg;
                                fcnt_reg              <= CNT_BITS'(1);
                            end
                        end
                        else if (!hit_reg)
                            emit(ACT_ABSENT, '0, cmd_reg.file_id, cmd_reg.page_number,
                                 1'b0, 1'b0, 1'b1);
                        else if (cmd_reg.op == OP_MARK_DIRTY)
                        begin
                            dirty_reg[hslot_reg] <= 1'b1;
                            emit(ACT_DONE, hslot_reg, cmd_reg.file_id,
                                 cmd_reg.page_number, 1'b1, 1'b1, 1'b1);
                        end
                        else if (cmd_reg.op == OP_DISCARD)
                        begin
                            for (int i = 0; i < NUM_SLOTS; i++)
                                if (valid_reg[i] && rank_reg[i] > rank_reg[hslot_reg])
                                    rank_reg[i] <= rank_reg[i] - SLOT_BITS'(1);
                            valid_reg[hslot_reg] <= 1'b0;
                            dirty_reg[hslot_reg] <= 1'b0;
                            stack_reg[fcnt_reg[SLOT_BITS-1:0]] <= hslot_reg;
                            fcnt_reg <= fcnt_reg + CNT_BITS'(1);
                            emit(ACT_DONE, hslot_reg, cmd_reg.file_id,
                                 cmd_reg.page_number, 1'b1, 1'b0, 1'b1);
                        end
                        else
                        begin
                            dirty_reg[hslot_reg] <= 1'b0;
                            emit(dirty_reg[hslot_reg] ? ACT_WRITEBACK : ACT_DONE, hslot_reg,
                                 cmd_reg.file_id, cmd_reg.page_number, 1'b1, 1'b0, 1'b1);
                        end
                    end
                ST_FILL:
                    if (free_ok)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (valid_reg[i])
                                rank_reg[i] <= rank_reg[i] + SLOT_BITS'(1);
                        rank_reg[victim_reg]  <= '0;
                        valid_reg[victim_reg] <= 1'b1;
                        file_reg[victim_reg]  <= cmd_reg.file_id;
                        page_reg[victim_reg]  <= cmd_reg.page_number;
                        fcnt_reg              <= '0;
                        emit(ACT_FILL, victim_reg, cmd_reg.file_id,
                             cmd_reg.page_number, 1'b0, 1'b0, 1'b1);
                    end
                ST_SCAN:
                    if (free_ok)
                    begin
                        scan_reg <= scan_reg + SLOT_BITS'(1);
                        if (f_match[scan_reg])
                        begin
                            // last write-back when no later slot matches
                            dirty_reg[scan_reg] <= 1'b0;
                            any_reg             <= 1'b1;
                            emit(ACT_WRITEBACK, scan_reg, cmd_reg.file_id,
                                 page_reg[scan_reg], 1'b0, 1'b0, !f_more);
                        end
                        else if (scan_reg == SLOT_BITS'(NUM_SLOTS - 1) && !any_reg)
                            emit(ACT_DONE, '0, cmd_reg.file_id, '0, 1'b0, 1'b0, 1'b1);
                    end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
